### design/smi_pkg.sv
// Shared types and constants for the min-max injection SVPWM block.
// Used by every module under design/; depends on nothing.
`default_nettype none

package smi_pkg;

  // Field widths and fixed-point formats
  localparam int VOLT_WIDTH     = 16;   // Q7.8 voltages
  localparam int DUTY_FRAC_BITS = 15;   // Q1.15 duties
  localparam int DUTY_W         = 16;
  localparam int STAT_W         = 2;

  // sqrt(3) in Q16
  localparam int SQRT3_Q16 = 113512;
  localparam int SQ_W      = 18;

  // Internal widths: doubled phase voltages, span, numerator, remainder
  localparam int PH_W   = VOLT_WIDTH + 18;
  localparam int SPAN_W = PH_W + 1;
  localparam int NUM_W  = VOLT_WIDTH + 22;
  localparam int REM_W  = VOLT_WIDTH + 18;
  localparam int QUO_W  = DUTY_FRAC_BITS + 1;
  localparam int CNT_W  = $clog2(DUTY_FRAC_BITS + 1);

  // Shift amounts of the fixed-point scaling
  localparam int SH_HALF  = 16;   // alpha * 2^16
  localparam int SH_FULL  = 17;   // alpha * 2^17, span limit bus * 2^17
  localparam int SH_M     = 18;   // M = bus * 2^18
  localparam int SH_DEN   = 19;   // 2M = bus * 2^19

  // Front/back queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_BUS = 2'd1,
    STAT_OVERMOD = 2'd2
  } status_t;

  typedef logic signed [VOLT_WIDTH-1:0] volt_t;

  // One classified transaction handed from front to back
  typedef struct packed {
    status_t                  status;
    logic [2:0]               zero;   // duty forced to zero
    logic [2:0]               full;   // duty saturates at full on
    logic [2:0][REM_W-1:0]    rem;    // dividend per phase
    logic [REM_W-1:0]         den;    // 2M
  } smi_entry_t;

endpackage

`default_nettype wire

### design/smi_front.sv
// Front end: accepts transactions, runs inverse Clarke, min/max injection
// and status checks in four stall-able stages. Depends on smi_pkg.
`default_nettype none

module smi_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire smi_pkg::volt_t        in_v_alpha,
  input  wire smi_pkg::volt_t        in_v_beta,
  input  wire smi_pkg::volt_t        in_bus_voltage,
  output logic                       push_valid,
  input  wire logic                  push_ready,
  output smi_pkg::smi_entry_t        push_entry
);

  localparam logic signed [smi_pkg::SQ_W-1:0] SQRT3_C = smi_pkg::SQ_W'(smi_pkg::SQRT3_Q16);

  // Stage valids and load enables
  logic v0_r, v1_r, v2_r, v3_r;
  logic v0_nxt, v1_nxt, v2_nxt, v3_nxt;
  logic ld0, ld1, ld2, ld3;

  assign ld3      = !v3_r || push_ready;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign ld0      = !v0_r || ld1;
  assign in_ready = ld0;

  always_comb begin
    v0_nxt = ld0 ? in_valid : v0_r;
    v1_nxt = ld1 ? v0_r     : v1_r;
    v2_nxt = ld2 ? v1_r     : v2_r;
    v3_nxt = ld3 ? v2_r     : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // Stage 0: capture inputs, sqrt(3) * beta
  smi_pkg::volt_t                   alpha0_r, bus0_r;
  smi_pkg::volt_t                   alpha0_nxt, bus0_nxt;
  logic signed [smi_pkg::PH_W-1:0]  prod0_r, prod0_nxt;

  assign alpha0_nxt = in_v_alpha;
  assign bus0_nxt   = in_bus_voltage;
  assign prod0_nxt  = smi_pkg::PH_W'(in_v_beta) * smi_pkg::PH_W'(SQRT3_C);

  always_ff @(posedge clk) begin
    if (ld0) begin
      alpha0_r <= alpha0_nxt;
      bus0_r   <= bus0_nxt;
      prod0_r  <= prod0_nxt;
    end
  end

  // Stage 1: doubled phase voltages, bus sign and zero check
  logic signed [smi_pkg::PH_W-1:0]  ph1_r [3];
  logic signed [smi_pkg::PH_W-1:0]  ph1_nxt [3];
  logic signed [smi_pkg::PH_W-1:0]  alpha_ext, alpha_half;
  smi_pkg::volt_t                   bus1_r;
  logic                             bad1_r, bad1_nxt;

  always_comb begin
    alpha_ext  = smi_pkg::PH_W'(alpha0_r);
    alpha_half = alpha_ext <<< smi_pkg::SH_HALF;
    ph1_nxt[0] = alpha_ext <<< smi_pkg::SH_FULL;
    ph1_nxt[1] = prod0_r - alpha_half;
    ph1_nxt[2] = -alpha_half - prod0_r;
    bad1_nxt   = bus0_r[smi_pkg::VOLT_WIDTH-1] || (bus0_r == '0);
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      for (int i = 0; i < 3; i++) ph1_r[i] <= ph1_nxt[i];
      bus1_r <= bus0_r;
      bad1_r <= bad1_nxt;
    end
  end

  // Stage 2: largest and smallest phase
  logic signed [smi_pkg::PH_W-1:0]  ph2_r [3];
  logic signed [smi_pkg::PH_W-1:0]  hi2_r, lo2_r, hi2_nxt, lo2_nxt;
  smi_pkg::volt_t                   bus2_r;
  logic                             bad2_r;

  always_comb begin
    hi2_nxt = ph1_r[0];
    lo2_nxt = ph1_r[0];
    for (int i = 1; i < 3; i++) begin
      if (ph1_r[i] > hi2_nxt) hi2_nxt = ph1_r[i];
      if (ph1_r[i] < lo2_nxt) lo2_nxt = ph1_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      for (int i = 0; i < 3; i++) ph2_r[i] <= ph1_r[i];
      hi2_r  <= hi2_nxt;
      lo2_r  <= lo2_nxt;
      bus2_r <= bus1_r;
      bad2_r <= bad1_r;
    end
  end

  // Stage 3: numerators M + 2*(2x - hi - lo), overmodulation check
  logic signed [smi_pkg::NUM_W-1:0]  num3_r [3];
  logic signed [smi_pkg::NUM_W-1:0]  num3_nxt [3];
  logic signed [smi_pkg::NUM_W-1:0]  m_ext, hilo_ext;
  logic signed [smi_pkg::SPAN_W-1:0] span, span_lim;
  smi_pkg::status_t                  status3_r, status3_nxt;
  smi_pkg::volt_t                    bus3_r;

  always_comb begin
    m_ext    = smi_pkg::NUM_W'(bus2_r) <<< smi_pkg::SH_M;
    hilo_ext = (smi_pkg::NUM_W'(hi2_r) + smi_pkg::NUM_W'(lo2_r)) <<< 1;
    for (int i = 0; i < 3; i++) begin
      num3_nxt[i] = m_ext + (smi_pkg::NUM_W'(ph2_r[i]) <<< 2) - hilo_ext;
    end
    span     = smi_pkg::SPAN_W'(hi2_r) - smi_pkg::SPAN_W'(lo2_r);
    span_lim = smi_pkg::SPAN_W'(bus2_r) <<< smi_pkg::SH_FULL;
    priority if (bad2_r) begin
      status3_nxt = smi_pkg::STAT_BAD_BUS;
    end else if (span > span_lim) begin
      status3_nxt = smi_pkg::STAT_OVERMOD;
    end else begin
      status3_nxt = smi_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      for (int i = 0; i < 3; i++) num3_r[i] <= num3_nxt[i];
      status3_r <= status3_nxt;
      bus3_r    <= bus2_r;
    end
  end

  // Classify each phase against the divisor 2M and build the queue entry
  logic signed [smi_pkg::NUM_W-1:0] den_s;

  always_comb begin
    den_s             = smi_pkg::NUM_W'(bus3_r) <<< smi_pkg::SH_DEN;
    push_entry.status = status3_r;
    push_entry.den    = smi_pkg::REM_W'(bus3_r[smi_pkg::VOLT_WIDTH-2:0]) << smi_pkg::SH_DEN;
    for (int i = 0; i < 3; i++) begin
      push_entry.zero[i] = (status3_r != smi_pkg::STAT_OK) || num3_r[i][smi_pkg::NUM_W-1] ||
                           (num3_r[i] == '0);
      push_entry.full[i] = !push_entry.zero[i] && (num3_r[i] >= den_s);
      push_entry.rem[i]  = num3_r[i][smi_pkg::REM_W-1:0];
    end
  end

  assign push_valid = v3_r;

endmodule

`default_nettype wire

### design/smi_queue.sv
// Two-entry queue between front and back ends.
// Depends on smi_pkg for the entry type and depth.
`default_nettype none

module smi_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push_valid,
  output logic                      push_ready,
  input  wire smi_pkg::smi_entry_t  push_entry,
  output logic                      pop_valid,
  input  wire logic                 pop_ready,
  output smi_pkg::smi_entry_t       pop_entry
);

  smi_pkg::smi_entry_t           entries_r [smi_pkg::Q_DEPTH];
  logic [smi_pkg::Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [smi_pkg::Q_CNT_W-1:0]   count_r, count_nxt;
  logic                          push, pop;

  assign push_ready = (count_r != smi_pkg::Q_CNT_W'(smi_pkg::Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = entries_r[rd_ptr_r];

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == smi_pkg::Q_PTR_W'(smi_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == smi_pkg::Q_PTR_W'(smi_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_entry;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= smi_pkg::Q_CNT_W'(smi_pkg::Q_DEPTH))
    else $error("queue occupancy above depth");

endmodule

`default_nettype wire

### design/smi_back.sv
// Back end: three restoring dividers (one quotient bit per cycle) produce the
// duties, with rounding and clamping, into an output register. Uses smi_pkg.
`default_nettype none

module smi_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  wire smi_pkg::smi_entry_t   q_entry,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [smi_pkg::DUTY_W-1:0] out_duty_a,
  output logic [smi_pkg::DUTY_W-1:0] out_duty_b,
  output logic [smi_pkg::DUTY_W-1:0] out_duty_c,
  output logic [smi_pkg::STAT_W-1:0] out_status
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  localparam logic [smi_pkg::QUO_W-1:0] FULL_ON = smi_pkg::QUO_W'(1) << smi_pkg::DUTY_FRAC_BITS;

  state_t                          state_r, state_nxt;
  logic [smi_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [smi_pkg::REM_W-1:0]       rem_r [3];
  logic [smi_pkg::REM_W-1:0]       rem_nxt [3];
  logic [smi_pkg::QUO_W-1:0]       quo_r [3];
  logic [smi_pkg::QUO_W-1:0]       quo_nxt [3];
  logic [smi_pkg::REM_W-1:0]       den_r, den_nxt;
  smi_pkg::status_t                status_r, status_nxt;
  logic [2:0]                      zero_r, zero_nxt, full_r, full_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [smi_pkg::DUTY_W-1:0]      duty_r [3];
  logic [smi_pkg::DUTY_W-1:0]      duty_nxt [3];
  smi_pkg::status_t                out_status_r, out_status_nxt;

  logic                            out_free, fin_fire, load_en;
  logic [smi_pkg::REM_W:0]         shifted [3];
  logic [smi_pkg::REM_W:0]         den_ext;
  logic [2:0]                      ge;
  logic [smi_pkg::QUO_W-1:0]       duty_fin [3];

  assign out_free = !out_valid_r || out_ready;
  assign fin_fire = (state_r == ST_FIN) && out_free;
  assign load_en  = q_valid && ((state_r == ST_IDLE) || fin_fire);
  assign q_ready  = load_en;

  // Divider step and final rounding per phase
  always_comb begin
    den_ext = {1'b0, den_r};
    for (int i = 0; i < 3; i++) begin
      shifted[i] = {rem_r[i], 1'b0};
      ge[i]      = (shifted[i] >= den_ext);
      priority if (zero_r[i]) begin
        duty_fin[i] = '0;
      end else if (full_r[i]) begin
        duty_fin[i] = FULL_ON;
      end else begin
        duty_fin[i] = quo_r[i] + smi_pkg::QUO_W'(ge[i]);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_valid) state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == smi_pkg::CNT_W'(smi_pkg::DUTY_FRAC_BITS - 1)) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = q_valid ? ST_DIV : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Working registers: load from queue or iterate
  always_comb begin
    cnt_nxt    = cnt_r;
    den_nxt    = den_r;
    status_nxt = status_r;
    zero_nxt   = zero_r;
    full_nxt   = full_r;
    for (int i = 0; i < 3; i++) begin
      rem_nxt[i] = rem_r[i];
      quo_nxt[i] = quo_r[i];
    end
    if (load_en) begin
      cnt_nxt    = '0;
      den_nxt    = q_entry.den;
      status_nxt = q_entry.status;
      zero_nxt   = q_entry.zero;
      full_nxt   = q_entry.full;
      for (int i = 0; i < 3; i++) begin
        rem_nxt[i] = q_entry.rem[i];
        quo_nxt[i] = '0;
      end
    end else if (state_r == ST_DIV) begin
      cnt_nxt = cnt_r + 1'b1;
      for (int i = 0; i < 3; i++) begin
        rem_nxt[i] = ge[i] ? smi_pkg::REM_W'(shifted[i] - den_ext)
                           : shifted[i][smi_pkg::REM_W-1:0];
        quo_nxt[i] = {quo_r[i][smi_pkg::QUO_W-2:0], ge[i]};
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    for (int i = 0; i < 3; i++) duty_nxt[i] = duty_r[i];
    if (fin_fire) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_r;
      for (int i = 0; i < 3; i++) duty_nxt[i] = smi_pkg::DUTY_W'(duty_fin[i]);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    den_r        <= den_nxt;
    status_r     <= status_nxt;
    zero_r       <= zero_nxt;
    full_r       <= full_nxt;
    out_status_r <= out_status_nxt;
    for (int i = 0; i < 3; i++) begin
      rem_r[i]  <= rem_nxt[i];
      quo_r[i]  <= quo_nxt[i];
      duty_r[i] <= duty_nxt[i];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_duty_a = duty_r[0];
  assign out_duty_b = duty_r[1];
  assign out_duty_c = duty_r[2];
  assign out_status = out_status_r;

  // A fault status always comes with zero duties
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != smi_pkg::STAT_OK) |->
      (duty_r[0] == '0) && (duty_r[1] == '0) && (duty_r[2] == '0))
    else $error("nonzero duty with fault status");

  // Duties never exceed full on
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (duty_r[0] <= smi_pkg::DUTY_W'(FULL_ON)) &&
      (duty_r[1] <= smi_pkg::DUTY_W'(FULL_ON)) && (duty_r[2] <= smi_pkg::DUTY_W'(FULL_ON)))
    else $error("duty above full on");

  // A finished result waits while the output register is occupied
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && !out_free |-> !q_ready ##1 (state_r == ST_FIN))
    else $error("finished result dropped under back-pressure");

endmodule

`default_nettype wire

### design/svpwm_minmax_injection.sv
// Min-max common-mode injection SVPWM, top level: front end, queue, back end.
// The back end divides one transaction at a time: a 15-step restoring divider,
// then a finish state; the front end takes one per cycle unless back-pressure
// from the queue stalls it.
// Reset (rst_n, synchronous, active low) clears stage valids, queue pointers,
// the sequencer and out_valid; datapath registers are not reset.
`default_nettype none

module svpwm_minmax_injection (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire smi_pkg::volt_t        in_v_alpha,
  input  wire smi_pkg::volt_t        in_v_beta,
  input  wire smi_pkg::volt_t        in_bus_voltage,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [smi_pkg::DUTY_W-1:0] out_duty_a,
  output logic [smi_pkg::DUTY_W-1:0] out_duty_b,
  output logic [smi_pkg::DUTY_W-1:0] out_duty_c,
  output logic [smi_pkg::STAT_W-1:0] out_status
);

  logic                 push_valid, push_ready, pop_valid, pop_ready;
  smi_pkg::smi_entry_t  push_entry, pop_entry;

  // Transform and classification
  smi_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_v_alpha     (in_v_alpha),
    .in_v_beta      (in_v_beta),
    .in_bus_voltage (in_bus_voltage),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_entry     (push_entry)
  );

  // Decoupling queue
  smi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // Division and output
  smi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (pop_valid),
    .q_ready    (pop_ready),
    .q_entry    (pop_entry),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_duty_a (out_duty_a),
    .out_duty_b (out_duty_b),
    .out_duty_c (out_duty_c),
    .out_status (out_status)
  );

endmodule

`default_nettype wire

### verif/tb.sv
// Testbench for svpwm_minmax_injection: directed and random alpha/beta/bus transactions.
// Holds its own duty predictor and a scoreboard class; depends on design/smi_pkg.sv and the DUT.
`timescale 1ns / 1ps

// Scoreboard: predicts duties for each accepted input, checks results in order
class duty_scoreboard;

  typedef struct {
    logic [smi_pkg::DUTY_W-1:0] duty_a;
    logic [smi_pkg::DUTY_W-1:0] duty_b;
    logic [smi_pkg::DUTY_W-1:0] duty_c;
    smi_pkg::status_t           status;
  } duty_set_t;

  duty_set_t expected_duties[$];
  int        errors = 0;

  task report_mismatch(string what);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // One phase: (M + 2*(2*x - hi - lo)) / 2M, clamped, scaled, rounded half up
  function logic [smi_pkg::DUTY_W-1:0] phase_duty(longint x2, longint hi, longint lo,
                                                  longint m);
    longint num;
    longint den;
    longint rem;
    longint quo;
    num = m + 2 * (2 * x2 - hi - lo);
    den = 2 * m;
    if (num <= 0) return '0;
    if (num >= den) return smi_pkg::DUTY_W'(longint'(1) << smi_pkg::DUTY_FRAC_BITS);
    rem = num;
    quo = 0;
    for (int i = 0; i < smi_pkg::DUTY_FRAC_BITS; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 1;
      end
    end
    if ((rem << 1) >= den) quo = quo + 1;
    return quo[smi_pkg::DUTY_W-1:0];
  endfunction

  function duty_set_t predict_duties(smi_pkg::volt_t alpha, smi_pkg::volt_t beta,
                                     smi_pkg::volt_t bus);
    duty_set_t res;
    longint    al;
    longint    be;
    longint    bv;
    longint    a2;
    longint    b2;
    longint    c2;
    longint    hi;
    longint    lo;
    longint    m;
    al = longint'(alpha);
    be = longint'(beta);
    bv = longint'(bus);
    res.duty_a = '0;
    res.duty_b = '0;
    res.duty_c = '0;
    // Bus check comes first
    if (bv <= 0) begin
      res.status = smi_pkg::STAT_BAD_BUS;
      return res;
    end
    // Doubled phase voltages, inverse Clarke
    a2 = al * 131072;
    b2 = -al * 65536 + longint'(smi_pkg::SQRT3_Q16) * be;
    c2 = -al * 65536 - longint'(smi_pkg::SQRT3_Q16) * be;
    hi = a2;
    if (b2 > hi) hi = b2;
    if (c2 > hi) hi = c2;
    lo = a2;
    if (b2 < lo) lo = b2;
    if (c2 < lo) lo = c2;
    // Overmodulation: span above bus voltage, no tolerance
    if (hi - lo > bv * 131072) begin
      res.status = smi_pkg::STAT_OVERMOD;
      return res;
    end
    m = bv * 262144;
    res.duty_a = phase_duty(a2, hi, lo, m);
    res.duty_b = phase_duty(b2, hi, lo, m);
    res.duty_c = phase_duty(c2, hi, lo, m);
    res.status = smi_pkg::STAT_OK;
    return res;
  endfunction

  function void note_input(smi_pkg::volt_t alpha, smi_pkg::volt_t beta,
                           smi_pkg::volt_t bus);
    expected_duties.push_back(predict_duties(alpha, beta, bus));
  endfunction

  task check_result(logic [smi_pkg::DUTY_W-1:0] da, logic [smi_pkg::DUTY_W-1:0] db,
                    logic [smi_pkg::DUTY_W-1:0] dc, logic [smi_pkg::STAT_W-1:0] st);
    duty_set_t exp_set;
    if (expected_duties.size() == 0) begin
      report_mismatch($sformatf("unexpected result a=%0d b=%0d c=%0d status=%0d",
                                da, db, dc, st));
      return;
    end
    exp_set = expected_duties.pop_front();
    if (st !== exp_set.status)
      report_mismatch($sformatf("status got %0d exp %0d", st, exp_set.status));
    if (da !== exp_set.duty_a)
      report_mismatch($sformatf("duty_a got %0d exp %0d", da, exp_set.duty_a));
    if (db !== exp_set.duty_b)
      report_mismatch($sformatf("duty_b got %0d exp %0d", db, exp_set.duty_b));
    if (dc !== exp_set.duty_c)
      report_mismatch($sformatf("duty_c got %0d exp %0d", dc, exp_set.duty_c));
  endtask

  function int pending();
    return expected_duties.size();
  endfunction

endclass

module tb;

  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 40;
  localparam int STALL_LIMIT  = 5000;
  localparam int PHASE_ITEMS  = 165;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  smi_pkg::volt_t             in_v_alpha;
  smi_pkg::volt_t             in_v_beta;
  smi_pkg::volt_t             in_bus_voltage;
  logic                       out_valid;
  logic                       out_ready;
  logic [smi_pkg::DUTY_W-1:0] out_duty_a;
  logic [smi_pkg::DUTY_W-1:0] out_duty_b;
  logic [smi_pkg::DUTY_W-1:0] out_duty_c;
  logic [smi_pkg::STAT_W-1:0] out_status;

  int in_idle_pct;
  int out_idle_pct;
  int hold_req;
  int stall_cycles = 0;

  duty_scoreboard sb = new();

  svpwm_minmax_injection DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_v_alpha     (in_v_alpha),
    .in_v_beta      (in_v_beta),
    .in_bus_voltage (in_bus_voltage),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_duty_a     (out_duty_a),
    .out_duty_b     (out_duty_b),
    .out_duty_c     (out_duty_c),
    .out_status     (out_status)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Transaction monitors
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_input(in_v_alpha, in_v_beta, in_bus_voltage);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_duty_a, out_duty_b, out_duty_c, out_status);
  end

  // Watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("svpwm_minmax_injection: mismatch");
      $finish;
    end
  end

  // Receiver: random back-pressure, long hold on request
  initial begin : receiver
    int hold_seen;
    hold_seen = 0;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= out_idle_pct);
      @(posedge clk);
    end
  end

  // Offer one transaction; valid stays up until accepted
  task automatic send_item(smi_pkg::volt_t alpha, smi_pkg::volt_t beta,
                           smi_pkg::volt_t bus);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_v_alpha     <= alpha;
    in_v_beta      <= beta;
    in_bus_voltage <= bus;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Pause the sender until every expected result has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  // Random transactions, mostly in the linear range
  task automatic run_random(int count);
    int sel;
    int bus_i;
    int lim_a;
    int lim_b;
    int al_i;
    int be_i;
    for (int n = 0; n < count; n++) begin
      sel   = $urandom_range(99);
      bus_i = ($urandom_range(99) < 20) ? $urandom_range(16, 1) : $urandom_range(32767, 1);
      if (sel < 65) begin
        // Inside or just around the hexagon's inscribed circle
        lim_a = (bus_i * 600) / 1024;
        lim_b = (bus_i * 600) / 1024;
        al_i  = int'($urandom_range(2 * lim_a)) - lim_a;
        be_i  = int'($urandom_range(2 * lim_b)) - lim_b;
      end else if (sel < 80) begin
        al_i  = int'($urandom_range(65535)) - 32768;
        be_i  = int'($urandom_range(65535)) - 32768;
        bus_i = int'($urandom_range(65535)) - 32768;
      end else if (sel < 90) begin
        al_i  = int'($urandom_range(65535)) - 32768;
        be_i  = int'($urandom_range(65535)) - 32768;
        bus_i = -int'($urandom_range(32768, 0));
      end else begin
        // Overmodulation edge on the alpha axis
        al_i = (2 * bus_i) / 3 + int'($urandom_range(2)) - 1;
        if ($urandom_range(1)) al_i = -al_i;
        be_i = ($urandom_range(1)) ? 0 : int'($urandom_range(2)) - 1;
      end
      send_item(smi_pkg::volt_t'(al_i), smi_pkg::volt_t'(be_i), smi_pkg::volt_t'(bus_i));
    end
  endtask

  // Stimulus and end of run
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_v_alpha     = '0;
    in_v_beta      = '0;
    in_bus_voltage = '0;
    in_idle_pct    = 0;
    out_idle_pct   = 0;
    hold_req       = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero and negative bus, field extremes, overmodulation edge, clamping
    send_item(16'sd0, 16'sd0, 16'sd1);
    send_item(16'sd0, 16'sd0, 16'sd0);
    send_item(16'sd0, 16'sd0, -16'sd32768);
    send_item(-16'sd32768, 16'sd0, -16'sd1);
    send_item(16'sd32767, 16'sd32767, 16'sd32767);
    send_item(-16'sd32768, -16'sd32768, 16'sd32767);
    send_item(16'sd32767, 16'sd0, 16'sd32767);
    send_item(16'sd2, 16'sd0, 16'sd3);
    send_item(-16'sd2, 16'sd0, 16'sd3);
    send_item(16'sd3, 16'sd0, 16'sd4);
    send_item(16'sd0, 16'sd1, 16'sd1);
    send_item(16'sd1, 16'sd0, 16'sd5);
    send_item(16'sd1, 16'sd1, 16'sd7);
    send_item(16'sd0, 16'sd0, 16'sd32767);
    send_item(16'sd100, -16'sd50, 16'sd32767);
    send_item(16'sd0, -16'sd32768, 16'sd32767);
    send_item(16'sd0, -16'sd16384, 16'sd32767);
    send_item(16'sd0, 16'sd18918, 16'sd32767);
    send_item(16'sd21844, 16'sd0, 16'sd32767);
    send_item(-16'sd21845, 16'sd0, 16'sd32767);
    send_item(16'sd16384, 16'sd9459, 16'sd32767);
    send_item(16'sd1, -16'sd1, 16'sd2);
    wait_drained();

    // Sender sparse idle, receiver heavy idle
    in_idle_pct  = 23;
    out_idle_pct <= 74;
    run_random(PHASE_ITEMS);

    // Receiver holds off while the sender keeps offering
    in_idle_pct = 0;
    hold_req    <= hold_req + 1;
    run_random(12);
    wait_drained();

    // Sender heavy idle, receiver sparse idle
    in_idle_pct  = 74;
    out_idle_pct <= 23;
    run_random(PHASE_ITEMS);
    wait_drained();

    // No idling on either side
    in_idle_pct  = 0;
    out_idle_pct <= 0;
    run_random(PHASE_ITEMS);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected results never came", sb.pending()));
    if (sb.errors == 0)
      $display("svpwm_minmax_injection: match");
    else
      $display("svpwm_minmax_injection: mismatch");
    $finish;
  end

endmodule

### filelist.f
design/smi_pkg.sv
design/smi_front.sv
design/smi_queue.sv
design/smi_back.sv
design/svpwm_minmax_injection.sv
verif/tb.sv
